/* hdl/qpm_pkg.sv */
// ----------------------------------------------------------------------------
// qpm_pkg: shared definitions for the quadratic-probe name map
// Field widths, default sizes, command and status codes and the controller
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package qpm_pkg;

    // Default sizes of the map.
    localparam int DEF_TABLE_CELLS = 31;
    localparam int DEF_PROBE_LIMIT = 15;
    localparam int DEF_NAME_CHARS  = 7;

    // Fixed field widths of the channels.
    localparam int MAX_NAME_CHARS = 7;
    localparam int CMD_W          = 2;
    localparam int CHAR_W         = 16;
    localparam int VAL_W          = 8;
    localparam int SLOT_W         = 5;

    // Home-slot hash: 32-bit sum of char[n] << (4*n), reduced four bits a cycle.
    localparam int HASH_W     = 32;
    localparam int CHAR_SHIFT = 4;
    localparam int SHAMT_W    = 5;
    localparam int RED_BITS   = 4;
    localparam int RED_STEPS  = HASH_W / RED_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2
    } qpm_cmd_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_REDUCE,
        S_PROBE,
        S_DONE
    } qpm_state_t;

endpackage

`default_nettype wire

/* hdl/qpm_if.sv */
// ----------------------------------------------------------------------------
// qpm_if: request and response channels of the name map
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface qpm_req_if;
    import qpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] name_c0;
    logic [CHAR_W-1:0] name_c1;
    logic [CHAR_W-1:0] name_c2;
    logic [CHAR_W-1:0] name_c3;
    logic [CHAR_W-1:0] name_c4;
    logic [CHAR_W-1:0] name_c5;
    logic [CHAR_W-1:0] name_c6;
    logic              overlong;
    logic [VAL_W-1:0]  new_value;

    modport source (
        output valid, command, name_c0, name_c1, name_c2, name_c3, name_c4,
               name_c5, name_c6, overlong, new_value,
        input  ready
    );
    modport sink (
        input  valid, command, name_c0, name_c1, name_c2, name_c3, name_c4,
               name_c5, name_c6, overlong, new_value,
        output ready
    );
endinterface

interface qpm_rsp_if;
    import qpm_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [VAL_W-1:0]  found_value;
    logic [SLOT_W-1:0] slot;

    modport source (
        output valid, status, found_value, slot,
        input  ready
    );
    modport sink (
        input  valid, status, found_value, slot,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/qpm_ram.sv */
// ----------------------------------------------------------------------------
// qpm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/quadratic_probe_name_map.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_name_map: open-addressing name map with quadratic probing
// Maps names of up to NAME_CHARS 16-bit characters to 8-bit values.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell memory, clearing every cell, and
// accepts no request until that is done. It then handles one request at a
// time. A request sums the hash over its NAME_CHARS characters, reduces it
// modulo TABLE_CELLS, and then probes the cell memory: the read for each
// probe is issued on the read port while the registered data of the
// previous probe is checked, and a request with no hit fails after
// PROBE_LIMIT probes. Overlong names and unknown commands fail without
// probing. A finished response waits in an output register, so the next
// request is taken while it is still unread.
`default_nettype none

module quadratic_probe_name_map #(
    parameter int TABLE_CELLS = qpm_pkg::DEF_TABLE_CELLS,
    parameter int PROBE_LIMIT = qpm_pkg::DEF_PROBE_LIMIT,
    parameter int NAME_CHARS  = qpm_pkg::DEF_NAME_CHARS
) (
    input wire logic   clk,
    input wire logic   rst_n,
    qpm_req_if.sink    req,
    qpm_rsp_if.source  rsp
);
    import qpm_pkg::*;

    localparam int CW  = $clog2(TABLE_CELLS);
    localparam int KW  = $clog2(PROBE_LIMIT + 1);
    localparam int LW  = $clog2(NAME_CHARS + 1);
    localparam int RCW = $clog2(RED_STEPS);
    localparam int EW  = NAME_CHARS * CHAR_W + VAL_W;
    localparam logic [CW:0]        MOD_VAL    = (CW + 1)'(TABLE_CELLS);
    localparam logic [SHAMT_W-1:0] SHIFT_LAST = SHAMT_W'(CHAR_SHIFT * (NAME_CHARS - 1));

    // Control state.
    qpm_state_t        state_reg, state_next;
    logic [CW-1:0]     clr_reg, clr_next;
    logic [SHAMT_W-1:0] sh_amt_reg, sh_amt_next;
    logic [RCW-1:0]    red_cnt_reg, red_cnt_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              chk_valid_reg, chk_valid_next;
    logic              chk_last_reg, chk_last_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Request and datapath payload.
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [CHAR_W-1:0] nm_reg [NAME_CHARS];
    logic [CHAR_W-1:0] nm_next [NAME_CHARS];
    logic [LW-1:0]     len_reg, len_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     cell_reg, cell_next;
    logic [CW-1:0]     inc_reg, inc_next;
    logic [CW-1:0]     chk_cell_reg, chk_cell_next;
    logic              res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_fval_reg, res_fval_next;
    logic [CW-1:0]     res_cell_reg, res_cell_next;
    logic              rsp_status_reg, rsp_status_next;
    logic [VAL_W-1:0]  rsp_fval_reg, rsp_fval_next;
    logic [SLOT_W-1:0] rsp_slot_reg, rsp_slot_next;

    // Cell memory: one entry per cell, {value, characters}.
    logic              ram_wr_en;
    logic [CW-1:0]     ram_wr_addr;
    logic [EW-1:0]     ram_wr_data;
    logic              ram_rd_en;
    logic [CW-1:0]     ram_rd_addr;
    logic [EW-1:0]     ram_rd_data;

    logic [CHAR_W-1:0] in_chars [MAX_NAME_CHARS];
    logic [CHAR_W-1:0] in_nm [NAME_CHARS];
    logic [LW-1:0]     in_len;
    logic [CHAR_W-1:0] st_chars [NAME_CHARS];
    logic [VAL_W-1:0]  st_value;
    logic              name_hit;
    logic              cell_empty;
    logic              probe_hit;
    logic [EW-1:0]     ins_entry;
    logic [EW-1:0]     del_entry;
    logic [CW:0]       cell_sum;
    logic [CW:0]       cell_wrap;
    logic [CW:0]       inc_sum;
    logic [CW:0]       inc_wrap;
    logic [CW:0]       red_t;
    logic [CW-1:0]     red_r;

    qpm_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_CELLS)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_chars[0] = req.name_c0;
    assign in_chars[1] = req.name_c1;
    assign in_chars[2] = req.name_c2;
    assign in_chars[3] = req.name_c3;
    assign in_chars[4] = req.name_c4;
    assign in_chars[5] = req.name_c5;
    assign in_chars[6] = req.name_c6;

    // Name length is the position of the first zero character.
    always_comb
    begin
        in_len = LW'(NAME_CHARS);
        for (int i = NAME_CHARS - 1; i >= 0; i--)
        begin
            if (in_chars[i] == '0)
            begin
                in_len = LW'(i);
            end
        end
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            in_nm[i] = (i < int'(in_len)) ? in_chars[i] : '0;
        end
    end

    // Stored names are zero padded, so equal length and equal characters
    // reduce to equal characters up to and including the terminator.
    always_comb
    begin
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            st_chars[i] = ram_rd_data[i * CHAR_W +: CHAR_W];
        end
        st_value   = ram_rd_data[EW-1 -: VAL_W];
        cell_empty = (st_chars[0] == '0);
        name_hit   = 1'b1;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (i <= int'(len_reg) && st_chars[i] != nm_reg[i])
            begin
                name_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            ins_entry[i * CHAR_W +: CHAR_W] = nm_reg[i];
        end
        ins_entry[EW-1 -: VAL_W] = val_reg;
        del_entry                = ram_rd_data;
        del_entry[0 +: CHAR_W]   = '0;
        del_entry[EW-1 -: VAL_W] = '0;
    end

    // Probe k visits home + k*k; the step between probes is the odd number
    // 2k+1, kept modulo TABLE_CELLS.
    always_comb
    begin
        cell_sum  = {1'b0, cell_reg} + {1'b0, inc_reg};
        cell_wrap = (cell_sum >= MOD_VAL) ? (cell_sum - MOD_VAL) : cell_sum;
        inc_sum   = {1'b0, inc_reg} + (CW + 1)'(2);
        inc_wrap  = (inc_sum >= MOD_VAL) ? (inc_sum - MOD_VAL) : inc_sum;
    end

    // Restoring remainder, RED_BITS hash bits per cycle, high bits first.
    always_comb
    begin
        red_r = rem_reg;
        red_t = '0;
        for (int b = 0; b < RED_BITS; b++)
        begin
            red_t = {red_r, acc_reg[HASH_W-1-b]};
            if (red_t >= MOD_VAL)
            begin
                red_t = red_t - MOD_VAL;
            end
            red_r = red_t[CW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        sh_amt_next     = sh_amt_reg;
        red_cnt_next    = red_cnt_reg;
        k_next          = k_reg;
        chk_valid_next  = 1'b0;
        chk_last_next   = chk_last_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        nm_next         = nm_reg;
        len_next        = len_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        cell_next       = cell_reg;
        inc_next        = inc_reg;
        chk_cell_next   = chk_cell_reg;
        res_status_next = res_status_reg;
        res_fval_next   = res_fval_reg;
        res_cell_next   = res_cell_reg;
        rsp_status_next = rsp_status_reg;
        rsp_fval_next   = rsp_fval_reg;
        rsp_slot_next   = rsp_slot_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_cell_reg;
        ram_wr_data     = ins_entry;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = cell_reg;
        probe_hit       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == CW'(TABLE_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.command;
                    val_next    = req.new_value;
                    nm_next     = in_nm;
                    len_next    = in_len;
                    acc_next    = '0;
                    sh_amt_next = '0;
                    res_status_next = STATUS_FAIL;
                    res_fval_next   = '0;
                    res_cell_next   = '0;
                    case (req.command)
                        CMD_INSERT, CMD_LOOKUP, CMD_DELETE:
                        begin
                            state_next = req.overlong ? S_DONE : S_SUM;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SUM:
            begin
                // Characters past the end are zero and add nothing. The
                // name rotates once round and is back in place at the end.
                acc_next = acc_reg + (HASH_W'(nm_reg[0]) << sh_amt_reg);
                for (int i = 0; i < NAME_CHARS - 1; i++)
                begin
                    nm_next[i] = nm_reg[i + 1];
                end
                nm_next[NAME_CHARS - 1] = nm_reg[0];
                if (sh_amt_reg == SHIFT_LAST)
                begin
                    state_next   = S_REDUCE;
                    rem_next     = '0;
                    red_cnt_next = '0;
                end
                else
                begin
                    sh_amt_next = sh_amt_reg + SHAMT_W'(CHAR_SHIFT);
                end
            end

            S_REDUCE:
            begin
                rem_next     = red_r;
                acc_next     = acc_reg << RED_BITS;
                red_cnt_next = red_cnt_reg + 1'b1;
                if (red_cnt_reg == RCW'(RED_STEPS - 1))
                begin
                    state_next = S_PROBE;
                    cell_next  = red_r;
                    inc_next   = CW'(1);
                    k_next     = '0;
                end
            end

            S_PROBE:
            begin
                // Issue the read for probe k while the data of probe k-1
                // is checked.
                if (k_reg != KW'(PROBE_LIMIT))
                begin
                    ram_rd_en      = 1'b1;
                    cell_next      = cell_wrap[CW-1:0];
                    inc_next       = inc_wrap[CW-1:0];
                    k_next         = k_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_cell_next  = cell_reg;
                    chk_last_next  = (k_reg == KW'(PROBE_LIMIT - 1));
                end
                if (chk_valid_reg)
                begin
                    probe_hit = (cmd_reg == CMD_INSERT) ? cell_empty : name_hit;
                    if (probe_hit)
                    begin
                        state_next      = S_DONE;
                        res_status_next = STATUS_OK;
                        res_cell_next   = chk_cell_reg;
                        res_fval_next   = (cmd_reg == CMD_LOOKUP) ? st_value : '0;
                        case (cmd_reg)
                            CMD_INSERT:
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = ins_entry;
                            end
                            CMD_DELETE:
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = del_entry;
                            end
                            default:
                            begin
                                ram_wr_en = 1'b0;
                            end
                        endcase
                    end
                    else if (chk_last_reg)
                    begin
                        state_next      = S_DONE;
                        res_status_next = STATUS_FAIL;
                        res_cell_next   = '0;
                        res_fval_next   = '0;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_fval_next   = res_fval_reg;
                    rsp_slot_next   = SLOT_W'(res_cell_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sh_amt_reg    <= '0;
            red_cnt_reg   <= '0;
            k_reg         <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sh_amt_reg    <= sh_amt_next;
            red_cnt_reg   <= red_cnt_next;
            k_reg         <= k_next;
            chk_valid_reg <= chk_valid_next;
            chk_last_reg  <= chk_last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        nm_reg         <= nm_next;
        len_reg        <= len_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        cell_reg       <= cell_next;
        inc_reg        <= inc_next;
        chk_cell_reg   <= chk_cell_next;
        res_status_reg <= res_status_next;
        res_fval_reg   <= res_fval_next;
        res_cell_reg   <= res_cell_next;
        rsp_status_reg <= rsp_status_next;
        rsp_fval_reg   <= rsp_fval_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_value = rsp_fval_reg;
    assign rsp.slot        = rsp_slot_reg;

    // The table changes only during the sweep or on a probe hit.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == S_CLEAR || (state_reg == S_PROBE && chk_valid_reg)))
        else $error("cell memory written outside the sweep or a probe hit");

    // Every checked probe has its read data from the previous cycle.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> $past(ram_rd_en))
        else $error("probe checked without a read issued");

    // Probe addresses stay inside the table.
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> ({1'b0, cell_reg} < MOD_VAL && {1'b0, inc_reg} < MOD_VAL))
        else $error("probe address out of range");

    // A response beat appears only when a request completes.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised without a finished request");

endmodule

`default_nettype wire
